@@ hw/rtl/slcm_pkg.sv @@
`default_nettype none
package slcm_pkg;

  localparam int KW_COUNT    = 9;
  localparam int KW_MAX_LEN  = 5;
  localparam int EXACT_COUNT = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [KW_COUNT-1:0] ALL_ALIVE = '1;

  // keyword text, list order; unused tail bytes are zero
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"C", "L", "E", "A", "R"},
    '{"P", "A", "I", "R", 8'h00},
    '{"D", "I", "S", "C", "O"},
    '{"A", "D", "V", 8'h00, 8'h00},
    '{"P", "L", "A", "Y", 8'h00},
    '{"V", "O", "L", "U", 8'h00},
    '{"V", "O", "L", "D", 8'h00},
    '{"N", "E", "X", "T", 8'h00},
    '{"P", "R", "E", "V", 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  typedef enum logic [3:0] {
    CMD_UNKNOWN  = 4'd0,
    CMD_CLEAR    = 4'd1,
    CMD_PAIR     = 4'd2,
    CMD_DISCO    = 4'd3,
    CMD_ADV      = 4'd4,
    CMD_PLAY     = 4'd5,
    CMD_VOLU     = 4'd6,
    CMD_VOLD     = 4'd7,
    CMD_NEXT     = 4'd8,
    CMD_PREV     = 4'd9,
    CMD_OVERFLOW = 4'd10
  } cmd_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic       eol;
    logic       zero;
    logic [7:0] ch;
  } item_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int p = 0; p < KW_MAX_LEN; p++) begin
      if (pos == 3'(p)) begin
        c = KW_TEXT[k][p];
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/slcm_front.sv @@
`default_nettype none
module slcm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [7:0]      in_rx_byte,
  output logic                 q_push,
  input  wire logic            q_full,
  output slcm_pkg::item_t      q_item
);
  import slcm_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_item  = item_r;

  always_comb begin
    item_nxt      = item_r;
    item_nxt.eol  = (in_rx_byte == CH_LF) || (in_rx_byte == CH_CR);
    item_nxt.zero = (in_rx_byte == CH_NUL);
    // fold a-z only
    if (in_rx_byte >= CH_LOWER_A && in_rx_byte <= CH_LOWER_Z) begin
      item_nxt.ch = in_rx_byte - CASE_DELTA;
    end else begin
      item_nxt.ch = in_rx_byte;
    end
    valid_nxt = accept || (valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/slcm_queue.sv @@
`default_nettype none
module slcm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire slcm_pkg::item_t wr_item,
  output logic                 valid,
  input  wire logic            pop,
  output slcm_pkg::item_t      rd_item
);
  import slcm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/slcm_back.sv @@
`default_nettype none
module slcm_back #(
  parameter int LINE_BUFFER_BYTES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire slcm_pkg::item_t q_item,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [3:0]           out_command_code
);
  import slcm_pkg::*;

  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [KW_COUNT-1:0] alive_r, alive_nxt;
  logic                ended_r, ended_nxt;
  logic                res_valid_r, res_valid_nxt;
  cmd_t                res_code_r, res_code_nxt;

  logic [KW_COUNT-1:0] longer, matched, eol_alive;
  logic                makes_result, go;
  cmd_t                eol_code;

  assign out_empty        = !res_valid_r;
  assign out_command_code = res_code_r;

  // keywords longer than the current length, and char compare at this position
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      longer[k]  = LEN_W'(KW_LEN[k]) > len_r;
      matched[k] = alive_r[k];
      if (len_r < LEN_W'(KW_LEN[k])) begin
        if (kw_char(k, len_r[2:0]) != q_item.ch) begin
          matched[k] = 1'b0;
        end
      end else if (k < EXACT_COUNT) begin
        matched[k] = 1'b0;
      end
    end
    eol_alive = ended_r ? alive_r : (alive_r & ~longer);
    eol_code  = CMD_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (eol_alive[k]) begin
        eol_code = cmd_t'(4'(k + 1));
      end
    end
  end

  assign makes_result = q_item.eol ? (len_r != '0) : (len_r == LEN_MAX);
  assign go    = q_valid && (!res_valid_r || out_pop || !makes_result);
  assign q_pop = go;

  always_comb begin
    len_nxt       = len_r;
    alive_nxt     = alive_r;
    ended_nxt     = ended_r;
    res_code_nxt  = res_code_r;
    res_valid_nxt = res_valid_r && !out_pop;
    if (go) begin
      if (q_item.eol) begin
        if (len_r != '0) begin
          res_valid_nxt = 1'b1;
          res_code_nxt  = eol_code;
          len_nxt       = '0;
          alive_nxt     = ALL_ALIVE;
          ended_nxt     = 1'b0;
        end
      end else if (len_r == LEN_MAX) begin
        res_valid_nxt = 1'b1;
        res_code_nxt  = CMD_OVERFLOW;
        len_nxt       = '0;
        alive_nxt     = ALL_ALIVE;
        ended_nxt     = 1'b0;
      end else begin
        if (!ended_r) begin
          if (q_item.zero) begin
            ended_nxt = 1'b1;
            alive_nxt = alive_r & ~longer;
          end else begin
            alive_nxt = matched;
          end
        end
        len_nxt = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      alive_r     <= ALL_ALIVE;
      ended_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      alive_r     <= alive_nxt;
      ended_r     <= ended_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_code_r <= res_code_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/serial_line_command_matcher.sv @@
`default_nettype none
// channel   ports                       direction  request
// input     in_push in_full in_rx_byte  in         one received byte
// result    out_pop out_empty           out        one command code
//           out_command_code
//
// one byte per cycle sustained while in_full is low; a byte reaches the matcher
// through the front register, then the two-entry queue
// a result is registered in the cycle after its line end or overflow byte is matched
// synchronous active-low reset clears the line state and empties all stages
// a held result stalls only bytes that would make another result; plain
// text bytes keep flowing, and the queue absorbs short stalls on either side
module serial_line_command_matcher #(
  parameter int LINE_BUFFER_BYTES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [3:0]      out_command_code
);
  import slcm_pkg::*;

  // front to queue
  logic  f_push, f_full;
  item_t f_item;
  // queue to back
  logic  b_valid, b_pop;
  item_t b_item;

  // front: accept the byte, fold case, flag line end and zero byte
  slcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .q_push     (f_push),
    .q_full     (f_full),
    .q_item     (f_item)
  );

  // short queue decoupling classification from matching
  slcm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .full    (f_full),
    .wr_item (f_item),
    .valid   (b_valid),
    .pop     (b_pop),
    .rd_item (b_item)
  );

  // back: incremental keyword match, line length, result register
  slcm_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (b_valid),
    .q_pop            (b_pop),
    .q_item           (b_item),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_command_code (out_command_code)
  );

endmodule
`default_nettype wire

@@ tb/sv/command_code_checker.sv @@
`default_nettype none
module command_code_checker #(
  parameter int LINE_BYTES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_empty,
  input  wire logic       out_pop,
  input  wire logic [3:0] out_command_code,
  output int              fail_count,
  output int              codes_waiting,
  output int              codes_checked,
  output int              overflows_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import slcm_pkg::*;

  localparam int WORD_COUNT = 9;
  localparam int EXACT_WORDS = 4;
  localparam cmd_t WORD_CODE [WORD_COUNT] = '{
    CMD_CLEAR, CMD_PAIR, CMD_DISCO, CMD_ADV, CMD_PLAY,
    CMD_VOLU, CMD_VOLD, CMD_NEXT, CMD_PREV
  };

  // exact-match words first, then the prefix words, in priority order
  function automatic string word_text(input int k);
    case (k)
      0: return "CLEAR";
      1: return "PAIR";
      2: return "DISCO";
      3: return "ADV";
      4: return "PLAY";
      5: return "VOLU";
      6: return "VOLD";
      7: return "NEXT";
      default: return "PREV";
    endcase
  endfunction

  int unsigned             line_len = 0;
  logic [WORD_COUNT-1:0]   word_alive = '1;
  bit                      text_done = 1'b0;
  cmd_t                    pending_codes [$];
  cmd_t                    want;

  task automatic drop_longer_words(input int unsigned n);
    string w;
    for (int k = 0; k < WORD_COUNT; k++) begin
      w = word_text(k);
      if (w.len() > n) word_alive[k] = 1'b0;
    end
  endtask

  task automatic restart_line();
    line_len = 0;
    word_alive = '1;
    text_done = 1'b0;
  endtask

  task automatic predict_line_byte(input logic [7:0] b);
    logic [7:0] up;
    cmd_t code;
    string w;
    if (b == CH_LF || b == CH_CR) begin
      // empty lines are silent
      if (line_len != 0) begin
        if (!text_done) drop_longer_words(line_len);
        code = CMD_UNKNOWN;
        for (int k = WORD_COUNT - 1; k >= 0; k--) begin
          if (word_alive[k]) code = WORD_CODE[k];
        end
        pending_codes.push_back(code);
        restart_line();
      end
    end else if (line_len >= LINE_BYTES - 1) begin
      pending_codes.push_back(CMD_OVERFLOW);
      restart_line();
    end else begin
      if (!text_done) begin
        if (b == CH_NUL) begin
          text_done = 1'b1;
          drop_longer_words(line_len);
        end else begin
          up = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_DELTA : b;
          for (int k = 0; k < WORD_COUNT; k++) begin
            w = word_text(k);
            if (line_len < w.len()) begin
              if (w[line_len] != up) word_alive[k] = 1'b0;
            end else if (k < EXACT_WORDS) begin
              word_alive[k] = 1'b0;
            end
          end
        end
      end
      line_len++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_line();
      pending_codes.delete();
      fail_count = 0;
      codes_checked = 0;
      overflows_checked = 0;
    end else begin
      // compare before predicting so a stray result cannot meet a fresh code
      if (out_pop && !out_empty) begin
        if (pending_codes.size() == 0) begin
          $error("command_code: no result expected, actual %0d", out_command_code);
          fail_count++;
        end else begin
          want = pending_codes.pop_front();
          if (out_command_code !== want) begin
            $error("command_code: expected %0d, actual %0d", want, out_command_code);
            fail_count++;
          end
          codes_checked++;
          if (want == CMD_OVERFLOW) overflows_checked++;
        end
      end
      if (in_push && !in_full) predict_line_byte(in_rx_byte);
    end
    codes_waiting = pending_codes.size();
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slcm_pkg::*;

  localparam int LINE_BYTES = 16;
  localparam int RANDOM_BYTES = 600;
  localparam int LONG_HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_rx_byte;
  logic       out_empty;
  logic       out_pop;
  logic [3:0] out_command_code;

  int fail_count;
  int codes_waiting;
  int codes_checked;
  int overflows_checked;

  int bytes_sent = 0;
  bit gaps_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  // 4 ns clock
  always #2 clk = ~clk;

  serial_line_command_matcher #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_rx_byte(in_rx_byte),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_command_code(out_command_code)
  );

  command_code_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_rx_byte(in_rx_byte),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_command_code(out_command_code),
    .fail_count(fail_count),
    .codes_waiting(codes_waiting),
    .codes_checked(codes_checked),
    .overflows_checked(overflows_checked)
  );

  // stimulus words; truncation, suffixes and case flips make the near misses
  function automatic string vocab_word(input int k);
    case (k)
      0: return "CLEAR";
      1: return "PAIR";
      2: return "DISCO";
      3: return "ADV";
      4: return "PLAY";
      5: return "VOLU";
      6: return "VOLD";
      7: return "NEXT";
      default: return "PREV";
    endcase
  endfunction

  // one byte request: optional idle cycles, then hold push until accepted;
  // returns at a falling edge with push still high
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_push <= 1'b0;
      in_rx_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] line_end();
    return $urandom_range(1) ? CH_CR : CH_LF;
  endfunction

  // anything but a line end
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task automatic send_random_line();
    int kind;
    int n;
    string w;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 62) begin
      // mostly well-formed commands with random case and damage
      w = vocab_word($urandom_range(8));
      n = ($urandom_range(4) == 0) ? $urandom_range(w.len(), 1) : w.len();
      for (int i = 0; i < n; i++) begin
        c = w[i];
        if ($urandom_range(1)) c = c + CASE_DELTA;
        if ($urandom_range(24) == 0) c = text_byte();
        send_byte(c);
      end
      // trailing text: tests prefix words, and a zero byte cutting the text
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(5))
            0: send_byte(CH_NUL);
            1: send_byte(text_byte());
            default: send_byte(8'($urandom_range(8'h5A, 8'h41)));
          endcase
        end
      end
      send_byte(line_end());
    end else if (kind < 72) begin
      // near or past the line limit: fifteen characters fit, sixteen overflow
      repeat ($urandom_range(LINE_BYTES + 3, LINE_BYTES - 2)) send_byte(text_byte());
      if ($urandom_range(1)) send_byte(line_end());
    end else if (kind < 80) begin
      send_byte(line_end());
    end else begin
      // raw noise, line ends included
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      send_byte(line_end());
    end
  endtask

  // result side: pops at random, with one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < 8) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // hard limit on the run
  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int random_start;
    int drain_cycles;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_rx_byte = 8'h00;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // mixed case prefix word with trailing text
    send_text("pLaYx");
    send_byte(CH_CR);
    // exact word, shortest one
    send_text("ADV");
    send_byte(CH_LF);
    // empty line gives nothing
    send_byte(CH_LF);
    // zero byte ends the text, high byte after it is only counted
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_byte(CH_CR);
    // sixteenth character overflows; the following line end finds an empty line
    repeat (LINE_BYTES) send_byte(8'h7F);
    send_byte(CH_CR);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      // one long result stall while lines keep coming, so the input backs up
      if (bytes_sent - random_start > 150) long_hold_req = 1'b1;
      // a stretch with no idling on either side
      gaps_on = !(bytes_sent - random_start >= 350 && bytes_sent - random_start < 480);
      send_random_line();
    end
    gaps_on = 1'b1;
    in_push <= 1'b0;

    // drain, then keep watching for stray results
    while (codes_waiting != 0) @(negedge clk);
    drain_cycles = 20;
    repeat (drain_cycles) @(negedge clk);

    $display("pushed %0d bytes, checked %0d command codes (%0d overflows),",
             bytes_sent, codes_checked, overflows_checked);
    $display("with random idling, one burst without gaps and a %0d-cycle result stall",
             LONG_HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
